[sv/fpsa_pkg.sv]
// Shared types, codes and constants of the segment allocator.
`timescale 1ns / 1ps

package fpsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int OWNER_BITS_DEF   = 8;

    localparam int SIZE_W   = 20;
    localparam int REQ_W    = 16;
    localparam int PID_W    = 8;
    localparam int ACTION_W = 2;
    localparam int METHOD_W = 2;
    localparam int STATUS_W = 2;
    localparam int OIDX_W   = 4;
    localparam int OTOT_W   = 5;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

    localparam logic [METHOD_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [METHOD_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [METHOD_W-1:0] FIT_WORST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOOWNER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [SIZE_W-1:0]   a;
        logic [SIZE_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [SIZE_W-1:0]   res;
        logic                borrow;
    } t_alu_rsp;

endpackage

[sv/fpsa_alu.sv]
// Shared adder of the allocator: saturating add and subtract with borrow.
`timescale 1ns / 1ps

module fpsa_alu (
    input  fpsa_pkg::t_alu_req i_req,
    output fpsa_pkg::t_alu_rsp o_rsp
);
    import fpsa_pkg::*;

    logic [SIZE_W:0] w_sum;
    logic [SIZE_W:0] w_diff;

    assign w_sum  = {1'b0, i_req.a} + {1'b0, i_req.b};
    assign w_diff = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_comb begin
        o_rsp = '0;
        unique case (i_req.op)
            ALU_ADD: begin
                o_rsp.res    = w_sum[SIZE_W] ? {SIZE_W{1'b1}} : w_sum[SIZE_W-1:0];
                o_rsp.borrow = 1'b0;
            end
            ALU_SUB: begin
                o_rsp.res    = w_diff[SIZE_W-1:0];
                o_rsp.borrow = w_diff[SIZE_W];
            end
            default: begin
                o_rsp.res    = '0;
                o_rsp.borrow = 1'b0;
            end
        endcase
    end

endmodule

[sv/fit_policy_segment_allocator_unit.sv]
// Top level of the segment allocator: segment table, sequencer and result register.
//
// Input channel: i_valid with o_stall; a beat carries action, request size, fit method
// and process id. Output channel: o_valid with i_stall; a beat carries status, segment
// index and segment total. One result beat follows every input beat, in order.
// The block takes one item at a time; o_stall is high from the accepting edge until the
// result is placed in the output register. The segment table is a memory with one read
// and one write per cycle, so the sequencer walks it one entry at a time:
//   load, undefined action or invalid fit method: the result follows directly.
//   allocate: a read and a fit test per scanned entry (plus a compare for best or worst fit),
//             a read and a write per entry moved for the leftover, then the leftover and pick writes.
//   free:     a read and a test per entry scanned for the owner, then a read and a write per
//             entry of the table for the merge of adjacent free segments.
// When the receiver stalls, the finished result waits in the output register and the
// next item is still accepted; a further result waits inside until the register frees.
// Reset empties the table (count zero), clears o_valid and returns to idle. The
// table contents themselves are not cleared; only entries below the count are read.
`timescale 1ns / 1ps

module fit_policy_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF,
    parameter int OWNER_BITS   = fpsa_pkg::OWNER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [fpsa_pkg::ACTION_W-1:0]   i_action,
    input  logic [fpsa_pkg::REQ_W-1:0]      i_request_size,
    input  logic [fpsa_pkg::METHOD_W-1:0]   i_fit_method,
    input  logic [fpsa_pkg::PID_W-1:0]      i_process_id,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [fpsa_pkg::STATUS_W-1:0]   o_status,
    output logic [fpsa_pkg::OIDX_W-1:0]     o_segment_index,
    output logic [fpsa_pkg::OTOT_W-1:0]     o_segment_total
);
    import fpsa_pkg::*;

    localparam int IW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW    = $clog2(MAX_SEGMENTS + 1);
    localparam int OB_IN = (OWNER_BITS < PID_W) ? OWNER_BITS : PID_W;

    typedef struct packed {
        logic [SIZE_W-1:0]     size;
        logic                  free;
        logic [OWNER_BITS-1:0] owner;
    } t_entry;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_ARD   = 14'b00000000000010,
        S_AFIT  = 14'b00000000000100,
        S_ACMP  = 14'b00000000001000,
        S_ADEC  = 14'b00000000010000,
        S_SRD   = 14'b00000000100000,
        S_SWR   = 14'b00000001000000,
        S_SPLIT = 14'b00000010000000,
        S_APICK = 14'b00000100000000,
        S_FRD   = 14'b00001000000000,
        S_FEV   = 14'b00010000000000,
        S_MRD   = 14'b00100000000000,
        S_MWR   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_entry r_mem [MAX_SEGMENTS];
    t_entry r_rdata;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_w, n_w;
    logic [IW-1:0]          r_pick, n_pick;
    logic                   r_found, n_found;
    logic [SIZE_W-1:0]      r_pick_size, n_pick_size;
    logic [SIZE_W-1:0]      r_left, n_left;
    logic [SIZE_W-1:0]      r_cand_left, n_cand_left;
    logic [REQ_W-1:0]       r_req, n_req;
    logic [METHOD_W-1:0]    r_method, n_method;
    logic [OWNER_BITS-1:0]  r_owner, n_owner;
    t_entry                 r_last, n_last;
    logic [STATUS_W-1:0]    r_res_status, n_res_status;
    logic [IW-1:0]          r_res_index, n_res_index;
    logic                   r_o_valid, n_o_valid;
    logic [STATUS_W-1:0]    r_o_status, n_o_status;
    logic [OIDX_W-1:0]      r_o_index, n_o_index;
    logic [OTOT_W-1:0]      r_o_total, n_o_total;

    logic                   w_we;
    logic [IW-1:0]          w_waddr;
    t_entry                 w_wdata;
    logic                   w_re;
    logic [IW-1:0]          w_raddr;

    t_alu_req               w_alu_req;
    t_alu_rsp               w_alu_rsp;

    logic                   w_accept;
    logic [OWNER_BITS-1:0]  w_owner_in;
    logic [CW-1:0]          w_pick_p1;
    logic [CW-1:0]          w_idx_m1;
    logic [CW-1:0]          w_w_m1;
    logic                   w_fits;
    t_entry                 w_cur;

    fpsa_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign o_stall         = (r_state != S_IDLE);
    assign w_accept        = i_valid && !o_stall;
    assign w_owner_in      = OWNER_BITS'(i_process_id[OB_IN-1:0]);
    assign w_pick_p1       = CW'(r_pick) + CW'(1);
    assign w_idx_m1        = r_idx - CW'(1);
    assign w_w_m1          = r_w - CW'(1);
    assign w_fits          = r_rdata.free && !w_alu_rsp.borrow;
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_segment_index = r_o_index;
    assign o_segment_total = r_o_total;

    always_comb begin
        w_cur = r_rdata;
        if (r_idx[IW-1:0] == r_pick) begin
            w_cur.free  = 1'b1;
            w_cur.owner = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_comb begin
        w_alu_req.op = ALU_SUB;
        w_alu_req.a  = r_rdata.size;
        w_alu_req.b  = SIZE_W'(r_req);
        unique case (r_state)
            S_ACMP: begin
                if (r_method == FIT_BEST) begin
                    w_alu_req.a = r_rdata.size;
                    w_alu_req.b = r_pick_size;
                end else begin
                    w_alu_req.a = r_pick_size;
                    w_alu_req.b = r_rdata.size;
                end
            end
            S_MWR: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = r_last.size;
                w_alu_req.b  = w_cur.size;
            end
            default: begin
                w_alu_req.op = ALU_SUB;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_w          = r_w;
        n_pick       = r_pick;
        n_found      = r_found;
        n_pick_size  = r_pick_size;
        n_left       = r_left;
        n_cand_left  = r_cand_left;
        n_req        = r_req;
        n_method     = r_method;
        n_owner      = r_owner;
        n_last       = r_last;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_index    = r_o_index;
        n_o_total    = r_o_total;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = r_idx[IW-1:0];

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req        = i_request_size;
                    n_method     = i_fit_method;
                    n_owner      = w_owner_in;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_pick       = '0;
                    n_res_status = ST_NOFIT;
                    n_res_index  = '0;
                    n_state      = S_DONE;
                    case (i_action)
                        ACT_LOAD: begin
                            if (r_count >= CW'(MAX_SEGMENTS)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_we         = 1'b1;
                                w_waddr      = r_count[IW-1:0];
                                w_wdata.size = SIZE_W'(i_request_size);
                                w_wdata.free = 1'b1;
                                w_wdata.owner = '0;
                                n_count      = r_count + CW'(1);
                                n_res_status = ST_OK;
                                n_res_index  = r_count[IW-1:0];
                            end
                        end
                        ACT_ALLOC: begin
                            if (i_fit_method == FIT_FIRST || i_fit_method == FIT_BEST ||
                                i_fit_method == FIT_WORST) begin
                                n_state = S_ARD;
                            end
                        end
                        ACT_FREE: begin
                            n_state = S_FRD;
                        end
                        default: begin
                            n_res_status = ST_NOFIT;
                        end
                    endcase
                end
            end
            S_ARD: begin
                if (r_idx == r_count) begin
                    n_state = S_ADEC;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_AFIT;
                end
            end
            S_AFIT: begin
                n_cand_left = w_alu_rsp.res;
                n_idx       = r_idx + CW'(1);
                n_state     = S_ARD;
                if (w_fits) begin
                    if (!r_found) begin
                        n_found     = 1'b1;
                        n_pick      = r_idx[IW-1:0];
                        n_pick_size = r_rdata.size;
                        n_left      = w_alu_rsp.res;
                        if (r_method == FIT_FIRST) begin
                            n_state = S_ADEC;
                        end
                    end else begin
                        n_idx   = r_idx;
                        n_state = S_ACMP;
                    end
                end
            end
            S_ACMP: begin
                if (w_alu_rsp.borrow) begin
                    n_pick      = r_idx[IW-1:0];
                    n_pick_size = r_rdata.size;
                    n_left      = r_cand_left;
                end
                n_idx   = r_idx + CW'(1);
                n_state = S_ARD;
            end
            S_ADEC: begin
                if (!r_found) begin
                    n_res_status = ST_NOFIT;
                    n_state      = S_DONE;
                end else if (r_left == '0) begin
                    n_state = S_APICK;
                end else if (r_count >= CW'(MAX_SEGMENTS)) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = r_count;
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                if (r_idx > w_pick_p1) begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_m1[IW-1:0];
                    n_state = S_SWR;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SWR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IW-1:0];
                w_wdata = r_rdata;
                n_idx   = w_idx_m1;
                n_state = S_SRD;
            end
            S_SPLIT: begin
                w_we          = 1'b1;
                w_waddr       = w_pick_p1[IW-1:0];
                w_wdata.size  = r_left;
                w_wdata.free  = 1'b1;
                w_wdata.owner = '0;
                n_count       = r_count + CW'(1);
                n_state       = S_APICK;
            end
            S_APICK: begin
                w_we          = 1'b1;
                w_waddr       = r_pick;
                w_wdata.size  = SIZE_W'(r_req);
                w_wdata.free  = 1'b0;
                w_wdata.owner = r_owner;
                n_res_status  = ST_OK;
                n_res_index   = r_pick;
                n_state       = S_DONE;
            end
            S_FRD: begin
                if (r_idx == r_count) begin
                    n_res_status = ST_NOOWNER;
                    n_state      = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_FEV;
                end
            end
            S_FEV: begin
                if (!r_rdata.free && r_rdata.owner == r_owner) begin
                    n_pick  = r_idx[IW-1:0];
                    n_idx   = '0;
                    n_w     = '0;
                    n_state = S_MRD;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_FRD;
                end
            end
            S_MRD: begin
                if (r_idx == r_count) begin
                    n_count      = r_w;
                    n_res_status = ST_OK;
                    n_res_index  = r_pick;
                    n_state      = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_MWR;
                end
            end
            S_MWR: begin
                w_we = 1'b1;
                if (r_w != '0 && r_last.free && w_cur.free) begin
                    w_waddr       = w_w_m1[IW-1:0];
                    w_wdata.size  = w_alu_rsp.res;
                    w_wdata.free  = 1'b1;
                    w_wdata.owner = r_last.owner;
                    n_last.size   = w_alu_rsp.res;
                end else begin
                    w_waddr = r_w[IW-1:0];
                    w_wdata = w_cur;
                    n_last  = w_cur;
                    n_w     = r_w + CW'(1);
                end
                n_idx   = r_idx + CW'(1);
                n_state = S_MRD;
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_index  = (r_res_status == ST_OK) ? OIDX_W'(r_res_index) : '0;
                    n_o_total  = OTOT_W'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_idx        <= n_idx;
        r_w          <= n_w;
        r_pick       <= n_pick;
        r_found      <= n_found;
        r_pick_size  <= n_pick_size;
        r_left       <= n_left;
        r_cand_left  <= n_cand_left;
        r_req        <= n_req;
        r_method     <= n_method;
        r_owner      <= n_owner;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_o_status   <= n_o_status;
        r_o_index    <= n_o_index;
        r_o_total    <= n_o_total;
    end

endmodule
